@@ hw/rtl/prpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared constants, types and command format of the phase run preamble
// detector.
// ----------------------------------------------------------------------------
package prpd_pkg;

	localparam int MAX_PREAMBLE = 32;
	localparam int SAMPLE_BITS  = 16;
	localparam int CNT_W        = $clog2(MAX_PREAMBLE + 1);
	localparam int IDX_W        = $clog2(MAX_PREAMBLE);
	localparam int PROD_W       = 2 * SAMPLE_BITS;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(8);
	localparam logic [CNT_W-1:0] LEN_MIN   = CNT_W'(2);
	localparam logic [CNT_W-1:0] LEN_MAX   = CNT_W'(MAX_PREAMBLE);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_PASS,
		OP_RELEASE
	} op_t;

	// cnt: store index for OP_STORE, run length for OP_RELEASE
	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] cnt;
		sample_t          s_i;
		sample_t          s_q;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EMIT,
		B_TAIL
	} bstate_t;

endpackage
`default_nettype wire

@@ hw/rtl/prpd_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_in_if
// Sample input channel: valid/ready handshake with I/Q and reset mark.
// ----------------------------------------------------------------------------
interface prpd_in_if import prpd_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t in_i;
	sample_t in_q;
	logic    reset_mark;

	modport source(output valid, output in_i, output in_q, output reset_mark, input ready);
	modport sink(input valid, input in_i, input in_q, input reset_mark, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/prpd_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_out_if
// Result output channel: valid/ready handshake with I/Q and framing flags.
// ----------------------------------------------------------------------------
interface prpd_out_if import prpd_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t out_i;
	sample_t out_q;
	logic    start_of_packet;
	logic    last;

	modport source(output valid, output out_i, output out_q, output start_of_packet,
		output last, input ready);
	modport sink(input valid, input out_i, input out_q, input start_of_packet,
		input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/prpd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_front
// Accepts samples, runs the differential phase test against the last stored
// sample and turns each sample into a store, pass or release command, or drops it.
// ----------------------------------------------------------------------------
module prpd_front import prpd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	prpd_in_if.sink               sample,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data,
	output cmd_t                  cmd,
	output logic                  cmd_push,
	input  wire logic             cmd_full
);

	logic [CNT_W-1:0]         preamble_len_q;
	logic [CNT_W-1:0]         count_q;
	logic                     locked_q;
	sample_t                  last_i_q;
	sample_t                  last_q_q;

	logic                     v_s1;
	sample_t                  x_i_s1;
	sample_t                  x_q_s1;
	logic                     mark_s1;
	logic signed [PROD_W-1:0] pa_s1, pb_s1, pc_s1, pd_s1;

	logic                     accept;
	logic [CNT_W-1:0]         len_eff;
	logic [CNT_W-1:0]         cnt_eff;
	logic                     lock_eff;
	logic                     full;
	logic signed [PROD_W:0]   re_w, im_w;
	logic signed [PROD_W+1:0] re_x, aim_w;
	logic                     match;
	logic                     need_push;
	logic                     done;
	logic                     upd_last;
	logic [CNT_W-1:0]         nxt_count;
	logic                     nxt_locked;

	assign sample.ready = !v_s1;
	assign accept       = sample.valid && !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			preamble_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_i_s1  <= sample.in_i;
			x_q_s1  <= sample.in_q;
			mark_s1 <= sample.reset_mark;
			pa_s1   <= PROD_W'(sample.in_i) * PROD_W'(last_i_q);
			pb_s1   <= PROD_W'(sample.in_q) * PROD_W'(last_q_q);
			pc_s1   <= PROD_W'(sample.in_q) * PROD_W'(last_i_q);
			pd_s1   <= PROD_W'(sample.in_i) * PROD_W'(last_q_q);
		end
	end

	always_comb begin
		if (preamble_len_q < LEN_MIN) begin
			len_eff = LEN_MIN;
		end else if (preamble_len_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = preamble_len_q;
		end
		cnt_eff  = mark_s1 ? '0 : count_q;
		lock_eff = mark_s1 ? 1'b0 : locked_q;
		full     = cnt_eff >= len_eff;

		// match when Re(x*conj(s)) > |Im(x*conj(s))|
		re_w  = (PROD_W+1)'(pa_s1) + (PROD_W+1)'(pb_s1);
		im_w  = (PROD_W+1)'(pc_s1) - (PROD_W+1)'(pd_s1);
		re_x  = (PROD_W+2)'(re_w);
		aim_w = im_w[PROD_W] ? -((PROD_W+2)'(im_w)) : (PROD_W+2)'(im_w);
		match = re_x > aim_w;

		cmd        = '{op: OP_STORE, cnt: '0, s_i: x_i_s1, s_q: x_q_s1};
		need_push  = 1'b0;
		upd_last   = 1'b0;
		nxt_count  = cnt_eff;
		nxt_locked = lock_eff;

		if (lock_eff) begin
			cmd.op    = OP_PASS;
			need_push = 1'b1;
		end else if (cnt_eff == '0) begin
			need_push = 1'b1;
			upd_last  = 1'b1;
			nxt_count = CNT_W'(1);
		end else if (match && !full) begin
			cmd.cnt   = cnt_eff;
			need_push = 1'b1;
			upd_last  = 1'b1;
			nxt_count = cnt_eff + CNT_W'(1);
		end else if (match) begin
			need_push = 1'b0;
		end else if (!full) begin
			need_push = 1'b1;
			upd_last  = 1'b1;
			nxt_count = CNT_W'(1);
		end else begin
			cmd.op     = OP_RELEASE;
			cmd.cnt    = cnt_eff;
			need_push  = 1'b1;
			nxt_count  = '0;
			nxt_locked = 1'b1;
		end

		done     = v_s1 && !(need_push && cmd_full);
		cmd_push = v_s1 && need_push && !cmd_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			locked_q <= 1'b0;
		end else if (done) begin
			count_q  <= nxt_count;
			locked_q <= nxt_locked;
		end
	end

	always_ff @(posedge clk) begin
		if (done && upd_last) begin
			last_i_q <= x_i_s1;
			last_q_q <= x_q_s1;
		end
	end

`ifndef NO_ASSERTIONS
	a_lock_empty: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> count_q == '0)
		else $error("locked with a nonempty store");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LEN_MAX)
		else $error("store count beyond capacity");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/prpd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_queue
// Short command FIFO between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module prpd_queue import prpd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t push_cmd,
	input  wire logic push,
	output logic      full,
	output cmd_t      head,
	output logic      empty,
	input  wire logic pop
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/prpd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prpd_back
// Executes commands: holds the sample store, replays a stored run on release
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module prpd_back import prpd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic empty,
	output logic      pop,
	prpd_out_if.source result
);

	logic [PROD_W-1:0] mem [MAX_PREAMBLE];
	logic [PROD_W-1:0] rd_data_q;

	bstate_t           state_q, state_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	sample_t           tail_i_q, tail_q_q;
	logic              tail_ld;

	logic              res_v_q;
	sample_t           res_i_q, res_q_q;
	logic              res_sop_q, res_last_q;

	logic              can_load;
	logic              load;
	sample_t           ld_i, ld_q;
	logic              ld_sop, ld_last;
	logic              mem_we;
	logic              rd_en;

	assign can_load = !res_v_q || result.ready;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		tail_ld = 1'b0;
		pop     = 1'b0;
		mem_we  = 1'b0;
		rd_en   = 1'b0;
		load    = 1'b0;
		ld_i    = tail_i_q;
		ld_q    = tail_q_q;
		ld_sop  = 1'b0;
		ld_last = 1'b1;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					unique case (head.op)
						OP_STORE: begin
							mem_we = 1'b1;
							pop    = 1'b1;
						end
						OP_PASS: begin
							if (can_load) begin
								load = 1'b1;
								ld_i = head.s_i;
								ld_q = head.s_q;
								pop  = 1'b1;
							end
						end
						OP_RELEASE: begin
							pop     = 1'b1;
							tail_ld = 1'b1;
							cnt_d   = head.cnt;
							idx_d   = '0;
							state_d = B_READ;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			B_READ: begin
				rd_en   = 1'b1;
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (can_load) begin
					load    = 1'b1;
					ld_i    = rd_data_q[PROD_W-1:SAMPLE_BITS];
					ld_q    = rd_data_q[SAMPLE_BITS-1:0];
					ld_sop  = idx_q == '0;
					ld_last = 1'b0;
					idx_d   = idx_q + CNT_W'(1);
					state_d = (idx_q + CNT_W'(1) == cnt_q) ? B_TAIL : B_READ;
				end
			end
			B_TAIL: begin
				if (can_load) begin
					load    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			if (load) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_ld) begin
			tail_i_q <= head.s_i;
			tail_q_q <= head.s_q;
		end
		if (load) begin
			res_i_q    <= ld_i;
			res_q_q    <= ld_q;
			res_sop_q  <= ld_sop;
			res_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head.cnt[IDX_W-1:0]] <= {head.s_i, head.s_q};
		end
		if (rd_en) begin
			rd_data_q <= mem[idx_q[IDX_W-1:0]];
		end
	end

	assign result.valid           = res_v_q;
	assign result.out_i           = res_i_q;
	assign result.out_q           = res_q_q;
	assign result.start_of_packet = res_sop_q;
	assign result.last            = res_last_q;

`ifndef NO_ASSERTIONS
	a_emit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT || state_q == B_READ) |-> idx_q < cnt_q)
		else $error("replay index beyond run length");
	a_sop_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && res_sop_q) |-> !res_last_q)
		else $error("start of packet on a closing transaction");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/phase_run_preamble_detector_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phase_run_preamble_detector_unit
// Differential phase preamble detector on 16-bit signed I/Q samples.
// ----------------------------------------------------------------------------
// Channels: sample (valid/ready, in_i, in_q, reset_mark) and result
// (valid/ready, out_i, out_q, start_of_packet, last). A transaction moves at
// a rising edge with valid and ready high. cfg_we/cfg_data write preamble_len
// (reset value 8); write only while the block is idle.
// A sample is held in the product register, then decided against the last
// stored sample; the next sample is taken once that decision completes, which
// waits while the command queue is full. A release replays the stored run by
// a registered store read per result, then the closing sample. A pass-through
// sample reaches the result register; a store or dropped sample gives none.
// A 2-entry command queue separates classification from output, so samples
// keep flowing while a result waits; when the receiver stalls, the queue
// fills and sample.ready drops.
// Reset (arst_n low) clears the store count, lock, queue and result valid.
// ----------------------------------------------------------------------------
module phase_run_preamble_detector_unit import prpd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	prpd_in_if.sink               sample,
	prpd_out_if.source            result,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_data
);

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic full;
	logic empty;
	logic pop;

	prpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (push_cmd),
		.cmd_push (push),
		.cmd_full (full)
	);

	prpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cmd (push_cmd),
		.push     (push),
		.full     (full),
		.head     (head),
		.empty    (empty),
		.pop      (pop)
	);

	prpd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire
